/* hdl/pwdm_pkg.sv */
// shared constants and types of the pulse width and duty meter
`timescale 1ns / 1ps

package pwdm_pkg;

  localparam int TIME_W = 16;
  localparam int DUTY_W = 10;
  localparam int CNT_W  = 6;
  localparam int MOP_W  = 17;
  localparam int PROD_W = 40;

  localparam logic [TIME_W-1:0] MIN_WIDTH_RESET = 16'd67;
  localparam int SAMPLES_DEFAULT = 50;

  localparam int DUTY_SCALE = 100;
  localparam int DUTY_DIV_A = 66;
  localparam int DUTY_DIV_B = 93;

  // reciprocal multipliers, exact for every 16-bit dividend
  localparam int DIV_A_SHIFT = TIME_W + $clog2(DUTY_DIV_A);
  localparam int DIV_B_SHIFT = TIME_W + $clog2(DUTY_DIV_B);
  localparam logic [MOP_W-1:0] DIV_A_MUL =
    MOP_W'(((64'd1 << DIV_A_SHIFT) + DUTY_DIV_A - 1) / DUTY_DIV_A);
  localparam logic [MOP_W-1:0] DIV_B_MUL =
    MOP_W'(((64'd1 << DIV_B_SHIFT) + DUTY_DIV_B - 1) / DUTY_DIV_B);
  localparam logic [MOP_W-1:0] SCALE_MUL = MOP_W'(DUTY_SCALE);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_SCALE,
    OP_DIV_A,
    OP_DIV_B,
    OP_DIV_N
  } pwdm_op_t;

  typedef struct packed {
    logic     start_rise;
    logic     start_fall;
    pwdm_op_t op;
    logic     fix_avg;
    logic     load_out;
  } pwdm_cmd_t;

  typedef struct packed {
    logic avg_due;
  } pwdm_status_t;

endpackage

/* hdl/pwdm_if.sv */
// valid/ready channel interfaces for edge, result and configuration beats
`timescale 1ns / 1ps

interface pwdm_in_if import pwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] edge_time;

  modport source(output valid, output edge_time, input ready);
  modport sink(input valid, input edge_time, output ready);
endinterface

interface pwdm_out_if import pwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_value;
  logic [TIME_W-1:0] average_width;
  logic              average_updated;
  logic              was_rising;

  modport source(output valid, output duty_value, output average_width,
                 output average_updated, output was_rising, input ready);
  modport sink(input valid, input duty_value, input average_width,
               input average_updated, input was_rising, output ready);
endinterface

interface pwdm_cfg_if import pwdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] min_width_ticks;

  modport source(output valid, output min_width_ticks, input ready);
  modport sink(input valid, input min_width_ticks, output ready);
endinterface

/* hdl/pulse_width_duty_meter.sv */
// Pulse width and duty meter, top level.
// in_ch carries one captured 16-bit timer value per signal edge; edges
// alternate and the first after reset is taken as rising. out_ch returns
// exactly one result beat per edge beat: duty figure, latest average high
// width, a flag for a freshly completed average and the edge polarity.
// cfg_ch writes min_width_ticks; it is always ready. It must be written only
// while no edge is in flight; the block itself does not enforce this.
// A rising edge passes through scale, reciprocal division, a second scale
// and a second reciprocal division on the one shared multiplier, then to
// emit; a falling edge passes its division state, which, when the edge
// completes an average, divides by the sample count and leads on to the
// offset correction before emit. in_ready is high only while the controller is idle.
// The result sits in an output register, so a new edge is taken while the
// previous result waits; if the receiver still stalls when the next result
// is done, the controller holds it until the register frees.
// Synchronous reset sets min_width_ticks to 67, clears sums, average and
// duty, empties the output register and expects a rising edge next.
`timescale 1ns / 1ps

module pulse_width_duty_meter import pwdm_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT
) (
  input  logic clk,
  input  logic rst_n,
  pwdm_in_if.sink    in_ch,
  pwdm_out_if.source out_ch,
  pwdm_cfg_if.sink   cfg_ch
);

  pwdm_cmd_t    cmd;
  pwdm_status_t status;
  logic         cfg_we;

  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid;

  pwdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .status   (status)
  );

  pwdm_datapath #(
    .SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .edge_time      (in_ch.edge_time),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_ch.min_width_ticks),
    .duty_value     (out_ch.duty_value),
    .average_width  (out_ch.average_width),
    .average_updated(out_ch.average_updated),
    .was_rising     (out_ch.was_rising)
  );

endmodule

/* hdl/pwdm_datapath.sv */
// datapath: width sum, average, duty scaling through a shared multiplier
`timescale 1ns / 1ps

module pwdm_datapath import pwdm_pkg::*; #(
  parameter int SAMPLES_PER_AVERAGE = SAMPLES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pwdm_cmd_t         cmd,
  output pwdm_status_t      status,
  input  logic [TIME_W-1:0] edge_time,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_data,
  output logic [DUTY_W-1:0] duty_value,
  output logic [TIME_W-1:0] average_width,
  output logic              average_updated,
  output logic              was_rising
);

  localparam int DIV_N_SHIFT = TIME_W + $clog2(SAMPLES_PER_AVERAGE);
  localparam logic [MOP_W-1:0] DIV_N_MUL = MOP_W'(
    ((64'd1 << DIV_N_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE);

  logic [TIME_W-1:0] min_r;
  logic [TIME_W-1:0] rise_r;
  logic [TIME_W-1:0] sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] avg_r;
  logic [DUTY_W-1:0] duty_r;
  logic              due_r;
  logic              rising_r;
  logic [TIME_W-1:0] acc_r;

  logic [DUTY_W-1:0] out_duty_r;
  logic [TIME_W-1:0] out_avg_r;
  logic              out_upd_r;
  logic              out_rise_r;

  logic [MOP_W-1:0]  mul_op;
  logic [PROD_W-1:0] prod;
  logic [TIME_W-1:0] width;
  logic [TIME_W-1:0] sum_new;
  logic [CNT_W-1:0]  cnt_new;

  always_comb begin
    unique case (cmd.op)
      OP_MUL_SCALE: mul_op = SCALE_MUL;
      OP_DIV_A:     mul_op = DIV_A_MUL;
      OP_DIV_B:     mul_op = DIV_B_MUL;
      OP_DIV_N:     mul_op = DIV_N_MUL;
      default:      mul_op = '0;
    endcase
  end

  assign prod    = PROD_W'(acc_r) * PROD_W'(mul_op);
  assign width   = edge_time - rise_r;
  assign sum_new = sum_r + width;
  assign cnt_new = cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r    <= MIN_WIDTH_RESET;
      rise_r   <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      avg_r    <= '0;
      duty_r   <= '0;
      due_r    <= 1'b0;
      rising_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_r <= cfg_data;
      end
      if (cmd.start_rise) begin
        rise_r   <= edge_time;
        rising_r <= 1'b1;
        due_r    <= 1'b0;
      end
      if (cmd.start_fall) begin
        rising_r <= 1'b0;
        if (cnt_new == CNT_LAST) begin
          due_r <= 1'b1;
          sum_r <= '0;
          cnt_r <= '0;
        end else begin
          due_r <= 1'b0;
          sum_r <= sum_new;
          cnt_r <= cnt_new;
        end
      end
      if (cmd.op == OP_DIV_B) begin
        duty_r <= prod[DIV_B_SHIFT +: DUTY_W];
      end
      if (cmd.fix_avg) begin
        avg_r <= (acc_r < min_r) ? acc_r + min_r : acc_r;
      end
    end
  end

  // working register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.start_rise) begin
      acc_r <= avg_r - min_r;
    end else if (cmd.start_fall) begin
      acc_r <= sum_new;
    end else begin
      unique case (cmd.op)
        OP_MUL_SCALE: acc_r <= prod[TIME_W-1:0];
        OP_DIV_A:     acc_r <= prod[DIV_A_SHIFT +: TIME_W];
        OP_DIV_B:     acc_r <= prod[DIV_B_SHIFT +: TIME_W];
        OP_DIV_N:     acc_r <= prod[DIV_N_SHIFT +: TIME_W];
        default:      acc_r <= acc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_duty_r <= duty_r;
      out_avg_r  <= avg_r;
      out_upd_r  <= due_r;
      out_rise_r <= rising_r;
    end
  end

  assign status.avg_due  = due_r;
  assign duty_value      = out_duty_r;
  assign average_width   = out_avg_r;
  assign average_updated = out_upd_r;
  assign was_rising      = out_rise_r;

endmodule

/* hdl/pwdm_ctrl.sv */
// controller: sequences each edge beat through the datapath
`timescale 1ns / 1ps

module pwdm_ctrl import pwdm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output pwdm_cmd_t    cmd,
  input  pwdm_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R_MUL1,
    ST_R_DIV1,
    ST_R_MUL2,
    ST_R_DIV2,
    ST_F_DIV,
    ST_F_FIX,
    ST_EMIT
  } state_t;

  state_t state_r;
  logic   expect_rising_r;
  logic   out_valid_r;
  logic   in_take;
  logic   out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_take   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '{start_rise: 1'b0, start_fall: 1'b0, op: OP_NONE,
            fix_avg: 1'b0, load_out: 1'b0};
    unique case (state_r)
      ST_IDLE: begin
        cmd.start_rise = in_take && expect_rising_r;
        cmd.start_fall = in_take && !expect_rising_r;
      end
      ST_R_MUL1: cmd.op = OP_MUL_SCALE;
      ST_R_DIV1: cmd.op = OP_DIV_A;
      ST_R_MUL2: cmd.op = OP_MUL_SCALE;
      ST_R_DIV2: cmd.op = OP_DIV_B;
      ST_F_DIV:  cmd.op = status.avg_due ? OP_DIV_N : OP_NONE;
      ST_F_FIX:  cmd.fix_avg = 1'b1;
      ST_EMIT:   cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      expect_rising_r <= 1'b1;
      out_valid_r     <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_take) begin
            expect_rising_r <= !expect_rising_r;
            state_r <= expect_rising_r ? ST_R_MUL1 : ST_F_DIV;
          end
        end
        ST_R_MUL1: state_r <= ST_R_DIV1;
        ST_R_DIV1: state_r <= ST_R_MUL2;
        ST_R_MUL2: state_r <= ST_R_DIV2;
        ST_R_DIV2: state_r <= ST_EMIT;
        ST_F_DIV:  state_r <= status.avg_due ? ST_F_FIX : ST_EMIT;
        ST_F_FIX:  state_r <= ST_EMIT;
        ST_EMIT: begin
          // wait here while the previous result beat is still held
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/pwdm_checker.sv */
// port-level checks of the meter, bound to the top level
`timescale 1ns / 1ps

module pwdm_checker import pwdm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DUTY_W-1:0] duty_value,
  input logic [TIME_W-1:0] average_width,
  input logic              average_updated,
  input logic              was_rising
);

  // in_ready is low in the cycle after an edge is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high straight after an edge beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(duty_value) &&
      $stable(average_width) && $stable(average_updated) && $stable(was_rising))
    else $error("stalled result beat changed");

  // averages complete only on falling edges
  a_update_on_fall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(average_updated && was_rising))
    else $error("average flagged on a rising edge");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> duty_value <= DUTY_W'(704))
    else $error("duty figure out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

endmodule

bind pulse_width_duty_meter pwdm_checker u_pwdm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .duty_value     (out_ch.duty_value),
  .average_width  (out_ch.average_width),
  .average_updated(out_ch.average_updated),
  .was_rising     (out_ch.was_rising)
);
